// ----- src/bcf_pkg.sv -----
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared types and constants of the Bezier curve flattener.
// ----------------------------------------------------------------------------
package bcf_pkg;

    localparam int MAX_DEPTH_DEF  = 6;
    localparam int COORD_BITS_DEF = 24;
    localparam int TOL_BITS       = 28;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 28'd64;

    localparam logic [1:0] MODE_MOVETO = 2'd0;
    localparam logic [1:0] MODE_LINETO = 2'd1;
    localparam logic [1:0] MODE_QUAD   = 2'd2;
    localparam logic [1:0] MODE_CUBIC  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic load;
        logic eval;
        logic split;
        logic emit;
        logic pop;
    } t_cmd;

    typedef struct packed {
        logic curve;
        logic flat;
        logic stack_empty;
    } t_stat;

endpackage

// ----- src/bcf_ctrl.sv -----
// ----------------------------------------------------------------------------
// bcf_ctrl
// Sequencer that walks the subdivision of one curve piece by piece.
// ----------------------------------------------------------------------------
module bcf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  bcf_pkg::t_stat i_stat,
    output bcf_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import bcf_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_accept && i_stat.curve) n_state = ST_EVAL;
            end
            ST_EVAL:   n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (i_stat.flat && i_stat.stack_empty) n_state = ST_IDLE;
                else n_state = ST_EVAL;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_accept;
            end
            ST_EVAL:   o_cmd.eval = 1'b1;
            ST_DECIDE: begin
                o_cmd.emit  = i_stat.flat;
                o_cmd.pop   = i_stat.flat && !i_stat.stack_empty;
                o_cmd.split = !i_stat.flat;
            end
            default:   o_busy = 1'b1;
        endcase
    end

endmodule

// ----- src/bcf_datapath.sv -----
// ----------------------------------------------------------------------------
// bcf_datapath
// Current piece, subdivision stack, error estimate and vertex output register.
// ----------------------------------------------------------------------------
module bcf_datapath #(
    parameter int MAX_DEPTH  = bcf_pkg::MAX_DEPTH_DEF,
    parameter int COORD_BITS = bcf_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bcf_pkg::t_cmd                i_cmd,
    output bcf_pkg::t_stat               o_stat,
    input  logic                         i_cfg_we,
    input  logic [bcf_pkg::TOL_BITS-1:0] i_cfg_data,
    input  logic [1:0]                   i_mode,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_ctrl1_x,
    input  logic signed [COORD_BITS-1:0] i_ctrl1_y,
    input  logic signed [COORD_BITS-1:0] i_ctrl2_x,
    input  logic signed [COORD_BITS-1:0] i_ctrl2_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_strobe,
    output logic signed [COORD_BITS-1:0] o_point_x,
    output logic signed [COORD_BITS-1:0] o_point_y,
    output logic                         o_starts_polyline,
    output logic                         o_last_point
);
    import bcf_pkg::*;

    localparam int W   = COORD_BITS;
    localparam int DW  = $clog2(MAX_DEPTH + 1);
    localparam int SAW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int EW0 = W + 4;
    localparam int EW  = (EW0 > TOL_BITS) ? EW0 : TOL_BITS;

    function automatic logic signed [W-1:0] mid(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        return s[W:1];
    endfunction

    function automatic logic [W+1:0] sdiff(input logic signed [W-1:0] a,
                                           input logic signed [W-1:0] b,
                                           input logic signed [W-1:0] c);
        logic signed [W+1:0] d;
        d = {{2{a[W-1]}}, a} + {{2{c[W-1]}}, c} - {b[W-1], b, 1'b0};
        return d[W+1] ? (W+2)'(-d) : d;
    endfunction

    logic [TOL_BITS-1:0] r_tol;
    logic signed [W-1:0] r_px [4];
    logic signed [W-1:0] r_py [4];
    logic                r_quad;
    logic [DW-1:0]       r_depth;
    logic [DW-1:0]       r_sp;
    logic signed [W-1:0] r_sx [MAX_DEPTH][4];
    logic signed [W-1:0] r_sy [MAX_DEPTH][4];
    logic [DW-1:0]       r_sd [MAX_DEPTH];
    logic [EW0-1:0]      r_err;
    logic                r_strobe;
    logic signed [W-1:0] r_point_x;
    logic signed [W-1:0] r_point_y;
    logic                r_starts_polyline;
    logic                r_last_point;

    logic [EW0-1:0]      err;
    logic signed [W-1:0] lx [4], ly [4], rx [4], ry [4];
    logic [DW-1:0]       sp_dec;
    logic                curve;

    always_comb begin
        if (r_quad) begin
            err = EW0'(sdiff(r_px[0], r_px[1], r_px[2])) +
                  EW0'(sdiff(r_py[0], r_py[1], r_py[2]));
        end else begin
            err = EW0'(sdiff(r_px[0], r_px[1], r_px[2])) +
                  EW0'(sdiff(r_py[0], r_py[1], r_py[2])) +
                  EW0'(sdiff(r_px[1], r_px[2], r_px[3])) +
                  EW0'(sdiff(r_py[1], r_py[2], r_py[3]));
        end
    end

    // Split the current piece at its parameter midpoint.
    always_comb begin
        logic signed [W-1:0] m0x, m1x, m2x, n0x, n1x, cx;
        logic signed [W-1:0] m0y, m1y, m2y, n0y, n1y, cy;
        m0x = mid(r_px[0], r_px[1]);  m0y = mid(r_py[0], r_py[1]);
        m1x = mid(r_px[1], r_px[2]);  m1y = mid(r_py[1], r_py[2]);
        m2x = mid(r_px[2], r_px[3]);  m2y = mid(r_py[2], r_py[3]);
        n0x = mid(m0x, m1x);          n0y = mid(m0y, m1y);
        n1x = mid(m1x, m2x);          n1y = mid(m1y, m2y);
        cx  = mid(n0x, n1x);          cy  = mid(n0y, n1y);
        if (r_quad) begin
            lx = '{r_px[0], m0x, n0x, n0x};  ly = '{r_py[0], m0y, n0y, n0y};
            rx = '{n0x, m1x, r_px[2], r_px[2]};
            ry = '{n0y, m1y, r_py[2], r_py[2]};
        end else begin
            lx = '{r_px[0], m0x, n0x, cx};   ly = '{r_py[0], m0y, n0y, cy};
            rx = '{cx, n1x, m2x, r_px[3]};   ry = '{cy, n1y, m2y, r_py[3]};
        end
    end

    assign sp_dec = r_sp - DW'(1);
    assign curve  = (i_mode == MODE_QUAD) || (i_mode == MODE_CUBIC);

    assign o_stat.curve       = curve;
    assign o_stat.flat        = (r_depth >= DW'(MAX_DEPTH)) ||
                                (EW'(r_err) < EW'(r_tol));
    assign o_stat.stack_empty = (r_sp == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= TOL_RESET;
            r_strobe <= 1'b0;
            r_sp     <= '0;
        end else begin
            if (i_cfg_we) r_tol <= i_cfg_data;
            r_strobe <= i_cmd.emit || (i_cmd.load && !curve);
            if (i_cmd.load) begin
                r_sp    <= '0;
                r_depth <= '0;
                r_quad  <= (i_mode == MODE_QUAD);
                r_px    <= '{i_start_x, i_ctrl1_x, i_ctrl2_x, i_end_x};
                r_py    <= '{i_start_y, i_ctrl1_y, i_ctrl2_y, i_end_y};
                if (i_mode == MODE_MOVETO) begin
                    r_point_x         <= i_start_x;
                    r_point_y         <= i_start_y;
                    r_starts_polyline <= 1'b1;
                    r_last_point      <= 1'b1;
                end else if (i_mode == MODE_LINETO) begin
                    r_point_x         <= i_ctrl1_x;
                    r_point_y         <= i_ctrl1_y;
                    r_starts_polyline <= 1'b0;
                    r_last_point      <= 1'b1;
                end
            end
            if (i_cmd.eval) r_err <= err;
            if (i_cmd.emit) begin
                r_point_x         <= r_quad ? r_px[2] : r_px[3];
                r_point_y         <= r_quad ? r_py[2] : r_py[3];
                r_starts_polyline <= 1'b0;
                r_last_point      <= (r_sp == '0);
            end
            if (i_cmd.pop) begin
                r_px    <= r_sx[sp_dec[SAW-1:0]];
                r_py    <= r_sy[sp_dec[SAW-1:0]];
                r_depth <= r_sd[sp_dec[SAW-1:0]];
                r_sp    <= sp_dec;
            end
            if (i_cmd.split) begin
                r_sx[r_sp[SAW-1:0]] <= rx;
                r_sy[r_sp[SAW-1:0]] <= ry;
                r_sd[r_sp[SAW-1:0]] <= r_depth + DW'(1);
                r_sp    <= r_sp + DW'(1);
                r_px    <= lx;
                r_py    <= ly;
                r_depth <= r_depth + DW'(1);
            end
        end
    end

    assign o_strobe          = r_strobe;
    assign o_point_x         = r_point_x;
    assign o_point_y         = r_point_y;
    assign o_starts_polyline = r_starts_polyline;
    assign o_last_point      = r_last_point;

endmodule

// ----- src/bezier_curve_flattener_core.sv -----
// ----------------------------------------------------------------------------
// bezier_curve_flattener_core
// Flattens moveto, lineto, quadratic and cubic path segments into vertices.
// ----------------------------------------------------------------------------
// A request is accepted when start is high and busy is low. A moveto or lineto
// gives its one vertex on o_strobe in the next cycle and leaves the block idle.
// A curve is subdivided depth first at midpoints, at most to depth MAX_DEPTH
// (six by default); every piece goes through an error estimate, then a
// decision. All pieces share the subdivision stack and its single
// evaluate-and-split step. Vertices appear on o_strobe for exactly one cycle
// each and cannot be stalled, so the receiver must take them as they come.
// The tolerance register can be written whenever o_cfg_ready is high, which
// it always is; it should only change while the block is idle.
module bezier_curve_flattener_core #(
    parameter int MAX_DEPTH  = bcf_pkg::MAX_DEPTH_DEF,
    parameter int COORD_BITS = bcf_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_mode,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_ctrl1_x,
    input  logic signed [COORD_BITS-1:0] i_ctrl1_y,
    input  logic signed [COORD_BITS-1:0] i_ctrl2_x,
    input  logic signed [COORD_BITS-1:0] i_ctrl2_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_strobe,
    output logic signed [COORD_BITS-1:0] o_point_x,
    output logic signed [COORD_BITS-1:0] o_point_y,
    output logic                         o_starts_polyline,
    output logic                         o_last_point,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bcf_pkg::TOL_BITS-1:0] i_cfg_data
);
    import bcf_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  accept;

    // The tolerance register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    bcf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bcf_datapath #(
        .MAX_DEPTH (MAX_DEPTH),
        .COORD_BITS(COORD_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (i_mode),
        .i_start_x        (i_start_x),
        .i_start_y        (i_start_y),
        .i_ctrl1_x        (i_ctrl1_x),
        .i_ctrl1_y        (i_ctrl1_y),
        .i_ctrl2_x        (i_ctrl2_x),
        .i_ctrl2_y        (i_ctrl2_y),
        .i_end_x          (i_end_x),
        .i_end_y          (i_end_y),
        .o_strobe         (o_strobe),
        .o_point_x        (o_point_x),
        .o_point_y        (o_point_y),
        .o_starts_polyline(o_starts_polyline),
        .o_last_point     (o_last_point)
    );

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Bezier curve flattener testbench
// Drives moveto, lineto, quadratic and cubic segment requests into the core,
// predicts the vertices by its own recursive midpoint subdivision and checks
// every strobed vertex in order against the predicted list.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import bcf_pkg::*;

    typedef struct {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic               starts;
        logic               last;
    } t_vertex;

    class vertex_board;
        t_vertex      pending[$];
        int           mismatches;
        int           unexpected;
        logic [27:0]  tol;

        function void push_vertex(longint x, longint y, bit starts);
            t_vertex v;
            if (pending.size() >= 100000) return;
            v.px = x[23:0];
            v.py = y[23:0];
            v.starts = starts;
            v.last = 1'b0;
            pending = {pending, v};
        endfunction

        function longint half_down(longint s);
            return s >>> 1;
        endfunction

        function longint labs(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint sdiff(longint ax, longint ay, longint bx, longint by,
                               longint cx, longint cy);
            return labs(ax + cx - 2 * bx) + labs(ay + cy - 2 * by);
        endfunction

        function void split_quad(longint x0, longint y0, longint x1, longint y1,
                                 longint x2, longint y2, int depth);
            longint ax, ay, bx, by, mx, my;
            if (depth >= MAX_DEPTH_DEF || sdiff(x0, y0, x1, y1, x2, y2) < longint'(tol))
            begin
                push_vertex(x2, y2, 1'b0);
                return;
            end
            ax = half_down(x0 + x1); ay = half_down(y0 + y1);
            bx = half_down(x1 + x2); by = half_down(y1 + y2);
            mx = half_down(ax + bx); my = half_down(ay + by);
            split_quad(x0, y0, ax, ay, mx, my, depth + 1);
            split_quad(mx, my, bx, by, x2, y2, depth + 1);
        endfunction

        function void split_cubic(longint x0, longint y0, longint x1, longint y1,
                                  longint x2, longint y2, longint x3, longint y3,
                                  int depth);
            longint ax, ay, bx, by, cx, cy, dx, dy, ex, ey, mx, my;
            longint err;
            err = sdiff(x0, y0, x1, y1, x2, y2) + sdiff(x1, y1, x2, y2, x3, y3);
            if (depth >= MAX_DEPTH_DEF || err < longint'(tol)) begin
                push_vertex(x3, y3, 1'b0);
                return;
            end
            ax = half_down(x0 + x1); ay = half_down(y0 + y1);
            bx = half_down(x1 + x2); by = half_down(y1 + y2);
            cx = half_down(x2 + x3); cy = half_down(y2 + y3);
            dx = half_down(ax + bx); dy = half_down(ay + by);
            ex = half_down(bx + cx); ey = half_down(by + cy);
            mx = half_down(dx + ex); my = half_down(dy + ey);
            split_cubic(x0, y0, ax, ay, dx, dy, mx, my, depth + 1);
            split_cubic(mx, my, ex, ey, cx, cy, x3, y3, depth + 1);
        endfunction

        // Notes one accepted segment request and appends its vertices.
        function void note_segment(logic [1:0] mode, logic signed [23:0] p[8]);
            int first;
            first = pending.size();
            case (mode)
                MODE_MOVETO: push_vertex(p[0], p[1], 1'b1);
                MODE_LINETO: push_vertex(p[2], p[3], 1'b0);
                MODE_QUAD:   split_quad(p[0], p[1], p[2], p[3], p[4], p[5], 0);
                default:     split_cubic(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], 0);
            endcase
            if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_vertex(t_vertex got);
            t_vertex want;
            if (pending.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected vertex x=%0d y=%0d", got.px, got.py);
                return;
            end
            want = pending.pop_front();
            if (got.px !== want.px || got.py !== want.py || got.starts !== want.starts
                || got.last !== want.last) begin
                mismatches++;
                if (mismatches + unexpected <= 10)
                    $display("vertex mismatch: want %0d,%0d s%0b l%0b got %0d,%0d s%0b l%0b",
                             want.px, want.py, want.starts, want.last,
                             got.px, got.py, got.starts, got.last);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_mode = MODE_MOVETO;
    logic signed [23:0] i_start_x = '0, i_start_y = '0, i_ctrl1_x = '0, i_ctrl1_y = '0;
    logic signed [23:0] i_ctrl2_x = '0, i_ctrl2_y = '0, i_end_x = '0, i_end_y = '0;
    logic               o_strobe;
    logic signed [23:0] o_point_x, o_point_y;
    logic               o_starts_polyline, o_last_point;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [27:0]        i_cfg_data = '0;

    vertex_board board;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    bit          timed_out = 1'b0;

    // A curve ends in at most 64 vertices at the default depth, so a worst
    // case segment is fully drained within DRAIN_CYCLES.
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 400000;

    always #4 i_clk = ~i_clk;

    bezier_curve_flattener_core dut (
        .i_clk, .i_rst_n, .start, .busy, .i_mode,
        .i_start_x, .i_start_y, .i_ctrl1_x, .i_ctrl1_y,
        .i_ctrl2_x, .i_ctrl2_y, .i_end_x, .i_end_y,
        .o_strobe, .o_point_x, .o_point_y, .o_starts_polyline, .o_last_point,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data
    );

    // Vertices are sampled at the rising edge; the cycle counter also lives here.
    always @(posedge i_clk) begin
        t_vertex got;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_strobe) begin
            got.px = o_point_x;
            got.py = o_point_y;
            got.starts = o_starts_polyline;
            got.last = o_last_point;
            board.check_vertex(got);
        end
    end

    // Ends a burst of requests and waits until every predicted vertex has come.
    task automatic wait_empty();
        start <= 1'b0;
        while (board.pending.size() != 0 && cycle_count < CYCLE_LIMIT) @(negedge i_clk);
    endtask

    // Waits until every predicted vertex has come, then lets the block settle.
    task automatic wait_drained();
        wait_empty();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes the tolerance register while the block is idle.
    task automatic write_tolerance(logic [27:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.tol = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sends one segment request; the prediction is made at the accepting edge.
    // Start stays high afterwards so that requests can follow back to back.
    task automatic send_segment(logic [1:0] mode, logic signed [23:0] p[8]);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_mode <= mode;
        i_start_x <= p[0]; i_start_y <= p[1]; i_ctrl1_x <= p[2]; i_ctrl1_y <= p[3];
        i_ctrl2_x <= p[4]; i_ctrl2_y <= p[5]; i_end_x <= p[6]; i_end_y <= p[7];
        do @(posedge i_clk); while (busy);
        board.note_segment(mode, p);
        @(negedge i_clk);
    endtask

    // Random coordinate: mostly small curves, sometimes anything in range.
    function automatic logic signed [23:0] rand_coord(int spread);
        if ($urandom_range(9) == 0) return 24'($urandom);
        return 24'($signed($urandom_range(2 * spread)) - spread);
    endfunction

    task automatic random_phase(int count);
        logic signed [23:0] p[8];
        int spread;
        for (int n = 0; n < count; n++) begin
            spread = ($urandom_range(3) == 0) ? 40000 : 3000;
            foreach (p[k]) p[k] = rand_coord(spread);
            send_segment(2'($urandom_range(3)), p);
        end
    endtask

    initial begin
        logic signed [23:0] p[8];
        logic [1:0]         m;
        board = new();
        board.tol = TOL_RESET;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with the reset tolerance: every mode at the field
        // extremes, ignored fields filled with junk, and a straight curve.
        for (int k = 0; k < 8; k++) begin
            m = 2'(k % 4);
            foreach (p[j]) p[j] = (k < 4) ? 24'sh7fffff : 24'sh800000;
            send_segment(m, p);
        end
        foreach (p[j]) p[j] = (j % 2) ? 24'sh800000 : 24'sh7fffff;
        for (int k = 0; k < 4; k++) send_segment(2'(k), p);
        foreach (p[j]) p[j] = 24'(j * 256);
        send_segment(MODE_QUAD, p);
        send_segment(MODE_CUBIC, p);
        foreach (p[j]) p[j] = 24'sh555555 ^ {24{j[0]}};
        send_segment(MODE_CUBIC, p);
        // Zero tolerance forces full depth on every curve.
        write_tolerance('0);
        foreach (p[j]) p[j] = rand_coord(5000);
        send_segment(MODE_QUAD, p);
        send_segment(MODE_CUBIC, p);
        // Largest tolerance makes every curve flat at once.
        write_tolerance(28'hfffffff);
        send_segment(MODE_QUAD, p);
        send_segment(MODE_CUBIC, p);

        // Random part in three idle regimes and several tolerances.
        write_tolerance(28'd64);
        send_idle_pct = 9;
        random_phase(30);
        write_tolerance(28'($urandom_range(4000)));
        send_idle_pct = 61;
        random_phase(30);
        // Hold off until all vertices are out before sending more.
        wait_empty();
        random_phase(10);
        write_tolerance(28'($urandom));
        send_idle_pct = 0;
        random_phase(20);
        write_tolerance(28'd1);
        random_phase(20);
        random_phase(1);

        wait_drained();
        if (board.mismatches == 0 && board.unexpected == 0 && board.pending.size() == 0
            && !timed_out)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        timed_out = 1'b1;
        $display("testbench: errors");
        $finish;
    end

endmodule

// ----- files.f -----
src/bcf_pkg.sv
src/bcf_ctrl.sv
src/bcf_datapath.sv
src/bezier_curve_flattener_core.sv
sim/testbench.sv
